>>> hdl/dll_pkg.sv
// ----------------------------------------------------------------------------
// dll_pkg
// Opcodes and status codes for the linked list engine.
// ----------------------------------------------------------------------------
package dll_pkg;

	localparam logic [3:0] OP_PUSH_BACK  = 4'd0;
	localparam logic [3:0] OP_PUSH_FRONT = 4'd1;
	localparam logic [3:0] OP_POP_BACK   = 4'd2;
	localparam logic [3:0] OP_POP_FRONT  = 4'd3;
	localparam logic [3:0] OP_RD_FRONT   = 4'd4;
	localparam logic [3:0] OP_WR_FRONT   = 4'd5;
	localparam logic [3:0] OP_RD_BACK    = 4'd6;
	localparam logic [3:0] OP_WR_BACK    = 4'd7;
	localparam logic [3:0] OP_RD_INDEX   = 4'd8;
	localparam logic [3:0] OP_WR_INDEX   = 4'd9;
	localparam logic [3:0] OP_INSERT     = 4'd10;
	localparam logic [3:0] OP_ERASE      = 4'd11;
	localparam logic [3:0] OP_RD_NODE    = 4'd12;
	localparam logic [3:0] OP_WR_NODE    = 4'd13;
	localparam logic [3:0] OP_CLEAR      = 4'd14;
	localparam logic [3:0] OP_BEGIN      = 4'd15;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_EMPTY    = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_BAD_POS  = 3'd3;
	localparam logic [2:0] ST_BAD_HNDL = 3'd4;

endpackage

>>> hdl/doubly_linked_list_engine.sv
// ----------------------------------------------------------------------------
// doubly_linked_list_engine
// Bounded doubly linked list held in an on-chip node pool.
// ----------------------------------------------------------------------------
// One command is taken per transfer (start high while busy low); its single
// result shows on the result ports for one cycle with done high and cannot be
// stalled. Every command passes the decide state and the done state; between
// them front/back reads add a value read, pop and erase an unlink and a free
// list push, and push and insert a link read and a neighbor patch, with a free
// list read first when the node comes off the free list. Indexed access walks
// from the head node by node, and clear unlinks one element after another.
// busy drops in the cycle the result is shown, so the next command can be
// taken at the same edge that takes the result. The cost comes from the single
// read port of the pool memories, whose read data is registered, and the
// spare write step an insert needs to patch both neighbors. Handles CAPACITY
// and CAPACITY+1 are the end and front markers. The in-use flags sit in a
// pool memory and are trusted only below the never-used count, so nothing
// needs clearing after reset.
// ----------------------------------------------------------------------------
module doubly_linked_list_engine #(
	parameter int CAPACITY   = 1024,
	parameter int DATA_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [3:0]                     opcode,
	input  logic signed [DATA_WIDTH-1:0]   value,
	input  logic [$clog2(CAPACITY)-1:0]    position,
	input  logic [$clog2(CAPACITY+2)-1:0]  node_handle,
	output logic                           done,
	output logic [2:0]                     status,
	output logic signed [DATA_WIDTH-1:0]   data,
	output logic [$clog2(CAPACITY+2)-1:0]  result_handle,
	output logic [$clog2(CAPACITY+2)-1:0]  next_handle,
	output logic [$clog2(CAPACITY+2)-1:0]  prior_handle,
	output logic [$clog2(CAPACITY+2)-1:0]  element_count
);
	localparam int AW = $clog2(CAPACITY);
	localparam int HW = $clog2(CAPACITY + 2);
	localparam logic [HW-1:0] END_H   = HW'(CAPACITY);
	localparam logic [HW-1:0] FRONT_H = HW'(CAPACITY + 1);

	// sequencer codes
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DISP   = 4'd1;  // handle read back, decide
	localparam logic [3:0] S_LINK   = 4'd2;  // node allocated, fetch insert point
	localparam logic [3:0] S_INSP   = 4'd3;  // have pred of insert point
	localparam logic [3:0] S_INSF   = 4'd4;  // patch neighbors of new node
	localparam logic [3:0] S_UNL    = 4'd5;  // have links of node to unlink
	localparam logic [3:0] S_FREED  = 4'd6;  // push freed node on free list
	localparam logic [3:0] S_WALK   = 4'd7;  // index walk step
	localparam logic [3:0] S_STEP   = 4'd8;  // successor of walked node back
	localparam logic [3:0] S_DONE   = 4'd9;
	localparam logic [3:0] S_FREE   = 4'd10; // free list pop data back
	localparam logic [3:0] S_ENDRD  = 4'd11; // value read data back

	logic [3:0]            state_q;
	logic [3:0]            op_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [AW-1:0]         pos_q;
	logic [HW-1:0]         h_q;       // target handle (insert point / node)
	logic [HW-1:0]         n_q;       // allocated or walked node
	logic [AW-1:0]         cnt_q;     // walk counter
	logic                  clr_q;     // clearing

	logic [HW-1:0]         first_q, last_q, free_q;
	logic [HW:0]           nun_q;
	logic [HW-1:0]         len_q;
	logic [DATA_WIDTH-1:0] fmark_q, emark_q;

	logic [2:0]            st_q;
	logic [DATA_WIDTH-1:0] dat_q;
	logic [HW-1:0]         rh_q, nh_q, ph_q;
	logic                  done_q;

	logic [AW-1:0]         raddr;
	logic [DATA_WIDTH-1:0] rval;
	logic [HW-1:0]         rnext, rprior;
	logic                  ruse;
	logic                  we_v, we_n, we_p, we_u;
	logic [AW-1:0]         wa_v, wa_n, wa_p, wa_u;
	logic [DATA_WIDTH-1:0] wv;
	logic [HW-1:0]         wn, wp;
	logic                  wu;
	logic                  hv;        // h_q is a node in use (valid in S_DISP)

	dll_pool #(.AW(AW), .HW(HW), .DW(DATA_WIDTH)) u_pool (
		.clk(clk), .raddr(raddr), .rval(rval), .rnext(rnext), .rprior(rprior),
		.ruse(ruse),
		.we_val(we_v), .waddr_val(wa_v), .wval(wv),
		.we_next(we_n), .waddr_next(wa_n), .wnext(wn),
		.we_prior(we_p), .waddr_prior(wa_p), .wprior(wp),
		.we_use(we_u), .waddr_use(wa_u), .wuse(wu)
	);

	// nodes at or above the never-used count were never allocated
	assign hv = ({1'b0, h_q} < nun_q) && ruse;

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign status        = st_q;
	assign data          = dat_q;
	assign result_handle = rh_q;
	assign next_handle   = nh_q;
	assign prior_handle  = ph_q;
	assign element_count = len_q;

	// One engine process: address/write strobes are combinational from state.
	logic [3:0]            state_d;
	logic [HW-1:0]         first_d, last_d, free_d, len_d, h_d, n_d;
	logic [HW:0]           nun_d;
	logic [DATA_WIDTH-1:0] fmark_d, emark_d, dat_d;
	logic [2:0]            st_d;
	logic [HW-1:0]         rh_d, nh_d, ph_d;
	logic                  done_d, clr_d;
	logic [AW-1:0]         cnt_d;
	logic [HW-1:0]         p_w, q_w;

	always_comb begin
		state_d = state_q;
		first_d = first_q; last_d = last_q; free_d = free_q; len_d = len_q;
		nun_d = nun_q; fmark_d = fmark_q; emark_d = emark_q;
		h_d = h_q; n_d = n_q; cnt_d = cnt_q; clr_d = clr_q;
		st_d = st_q; dat_d = dat_q; rh_d = rh_q; nh_d = nh_q; ph_d = ph_q;
		done_d = 1'b0;
		raddr = '0;
		we_v = 1'b0; we_n = 1'b0; we_p = 1'b0; we_u = 1'b0;
		wa_v = n_q[AW-1:0]; wa_n = n_q[AW-1:0]; wa_p = n_q[AW-1:0];
		wa_u = n_q[AW-1:0];
		wv = val_q; wn = '0; wp = '0; wu = 1'b0;
		p_w = '0; q_w = '0;
		case (state_q)
			S_IDLE: begin
				// fetch the handled node now so its flag and links are ready
				raddr = node_handle[AW-1:0];
				if (start) begin
					state_d = S_DISP;
					st_d = dll_pkg::ST_OK; dat_d = '0; rh_d = '0; nh_d = '0; ph_d = '0;
					h_d = node_handle; cnt_d = '0; clr_d = 1'b0;
				end
			end
			S_DISP: begin
				state_d = S_DONE;
				case (op_q)
					dll_pkg::OP_PUSH_BACK, dll_pkg::OP_PUSH_FRONT, dll_pkg::OP_INSERT: begin
						if (op_q == dll_pkg::OP_PUSH_BACK) h_d = END_H;
						else if (op_q == dll_pkg::OP_PUSH_FRONT) h_d = first_q;
						if (op_q == dll_pkg::OP_INSERT && !(h_q == END_H || hv))
							st_d = dll_pkg::ST_BAD_HNDL;
						else if (free_q < END_H) begin
							n_d = free_q; raddr = free_q[AW-1:0]; state_d = S_FREE;
						end else if (nun_q < {1'b0, END_H}) begin
							n_d = nun_q[HW-1:0]; nun_d = nun_q + (HW+1)'(1); state_d = S_LINK;
						end else st_d = dll_pkg::ST_FULL;
					end
					dll_pkg::OP_POP_BACK, dll_pkg::OP_POP_FRONT: begin
						h_d = (op_q == dll_pkg::OP_POP_BACK) ? last_q : first_q;
						if (len_q == '0 || h_d >= END_H) st_d = dll_pkg::ST_EMPTY;
						else begin
							raddr = h_d[AW-1:0]; state_d = S_UNL;
						end
					end
					dll_pkg::OP_RD_FRONT, dll_pkg::OP_WR_FRONT,
					dll_pkg::OP_RD_BACK, dll_pkg::OP_WR_BACK: begin
						n_d = (op_q < dll_pkg::OP_RD_BACK) ? first_q : last_q;
						if (len_q == '0 || n_d >= END_H) begin
							st_d = dll_pkg::ST_EMPTY;
							case (op_q)
								dll_pkg::OP_RD_FRONT: dat_d = fmark_q;
								dll_pkg::OP_RD_BACK:  dat_d = emark_q;
								dll_pkg::OP_WR_FRONT: fmark_d = val_q;
								default:              emark_d = val_q;
							endcase
						end else if (op_q == dll_pkg::OP_RD_FRONT || op_q == dll_pkg::OP_RD_BACK) begin
							raddr = n_d[AW-1:0]; state_d = S_ENDRD;
						end else begin
							we_v = 1'b1; wa_v = n_d[AW-1:0];
						end
					end
					dll_pkg::OP_RD_INDEX, dll_pkg::OP_WR_INDEX: begin
						if (int'(pos_q) >= int'(len_q))
							st_d = dll_pkg::ST_BAD_POS;
						else begin
							n_d = first_q; state_d = S_WALK;
						end
					end
					dll_pkg::OP_ERASE: begin
						if (!hv) st_d = dll_pkg::ST_BAD_HNDL;
						else begin
							raddr = h_q[AW-1:0]; state_d = S_UNL;
						end
					end
					dll_pkg::OP_RD_NODE, dll_pkg::OP_WR_NODE: begin
						if (h_q == FRONT_H) begin
							if (op_q == dll_pkg::OP_RD_NODE) begin
								dat_d = fmark_q; nh_d = first_q; ph_d = FRONT_H;
							end else fmark_d = val_q;
						end else if (h_q == END_H) begin
							if (op_q == dll_pkg::OP_RD_NODE) begin
								dat_d = emark_q; nh_d = END_H; ph_d = last_q;
							end else emark_d = val_q;
						end else if (hv) begin
							// node contents were fetched at the accepting edge
							if (op_q == dll_pkg::OP_RD_NODE) begin
								dat_d = rval; nh_d = rnext; ph_d = rprior;
							end else begin
								we_v = 1'b1; wa_v = h_q[AW-1:0];
							end
						end else st_d = dll_pkg::ST_BAD_HNDL;
					end
					dll_pkg::OP_CLEAR: begin
						// every list member is in use, so the head alone says when to stop
						clr_d = 1'b1; h_d = first_q;
						if (first_q < END_H) begin
							raddr = first_q[AW-1:0]; state_d = S_UNL;
						end
					end
					default: rh_d = first_q;
				endcase
			end
			S_ENDRD: begin
				dat_d = rval; state_d = S_DONE;
			end
			S_FREE: begin
				// rnext holds the free list successor
				free_d = rnext; state_d = S_LINK;
			end
			S_LINK: begin
				// predecessor of insert point; the end marker's comes from last_q
				raddr = h_q[AW-1:0]; state_d = S_INSP;
			end
			S_INSP: begin
				p_w = (h_q == END_H) ? last_q : rprior;
				we_v = 1'b1; wa_v = n_q[AW-1:0]; wv = val_q;
				we_n = 1'b1; wa_n = n_q[AW-1:0]; wn = h_q;
				we_p = 1'b1; wa_p = n_q[AW-1:0]; wp = p_w;
				we_u = 1'b1; wa_u = n_q[AW-1:0]; wu = 1'b1;
				if (h_q == END_H) last_d = n_q;
				if (p_w == FRONT_H) first_d = n_q;
				len_d = len_q + HW'(1);
				rh_d = n_q;
				// write ports are busy with the new node; neighbors go next cycle
				h_d = p_w;
				nh_d = h_q;
				state_d = S_INSF;
			end
			S_INSF: begin
				// prior of old insert point, next of pred
				if (nh_q != END_H) begin
					we_p = 1'b1; wa_p = nh_q[AW-1:0]; wp = n_q;
				end
				if (h_q != FRONT_H) begin
					we_n = 1'b1; wa_n = h_q[AW-1:0]; wn = n_q;
				end
				nh_d = '0; state_d = S_DONE;
			end
			S_UNL: begin
				p_w = rprior; q_w = rnext;
				if (p_w == FRONT_H) first_d = q_w;
				else begin
					we_n = 1'b1; wa_n = p_w[AW-1:0]; wn = q_w;
				end
				if (q_w == END_H) last_d = p_w;
				else begin
					we_p = 1'b1; wa_p = q_w[AW-1:0]; wp = p_w;
				end
				we_u = 1'b1; wa_u = h_q[AW-1:0]; wu = 1'b0;
				if (len_q != '0) len_d = len_q - HW'(1);
				state_d = S_FREED;
				n_d = q_w;
			end
			S_FREED: begin
				we_n = 1'b1; wa_n = h_q[AW-1:0]; wn = free_q;
				free_d = h_q;
				if (op_q == dll_pkg::OP_ERASE) rh_d = n_q;
				state_d = S_DONE;
				if (clr_q && n_q < END_H) begin
					h_d = n_q; raddr = n_q[AW-1:0]; state_d = S_UNL;
				end
			end
			S_WALK: begin
				if (n_q >= END_H) begin
					st_d = dll_pkg::ST_BAD_POS; state_d = S_DONE;
				end else if (cnt_q == pos_q) begin
					if (op_q == dll_pkg::OP_RD_INDEX) begin
						raddr = n_q[AW-1:0]; state_d = S_ENDRD;
					end else begin
						we_v = 1'b1; wa_v = n_q[AW-1:0]; state_d = S_DONE;
					end
				end else begin
					raddr = n_q[AW-1:0]; state_d = S_STEP;
				end
			end
			S_STEP: begin
				n_d = rnext; cnt_d = cnt_q + AW'(1); state_d = S_WALK;
			end
			S_DONE: begin
				done_d = 1'b1; state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			first_q <= END_H; last_q <= FRONT_H; free_q <= END_H;
			nun_q <= '0; len_q <= '0; fmark_q <= '0; emark_q <= '0;
			done_q <= 1'b0; clr_q <= 1'b0;
		end else begin
			state_q <= state_d;
			first_q <= first_d; last_q <= last_d; free_q <= free_d;
			nun_q <= nun_d; len_q <= len_d; fmark_q <= fmark_d; emark_q <= emark_d;
			done_q <= done_d; clr_q <= clr_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q <= opcode; val_q <= value; pos_q <= position;
		end
		h_q <= h_d; n_q <= n_d; cnt_q <= cnt_d;
		st_q <= st_d; dat_q <= dat_d; rh_q <= rh_d; nh_q <= nh_d; ph_q <= ph_d;
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("done without command");
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= END_H) else $error("length above capacity");
	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && len_q == '0) |-> (first_q == END_H && last_q == FRONT_H))
		else $error("empty list with dangling ends");
endmodule

>>> hdl/dll_pool.sv
// ----------------------------------------------------------------------------
// dll_pool
// Node pool: value, successor, predecessor and in-use memories, one read and
// one write port each, registered read data.
// ----------------------------------------------------------------------------
module dll_pool #(
	parameter int AW = 10,
	parameter int HW = 11,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rval,
	output logic [HW-1:0] rnext,
	output logic [HW-1:0] rprior,
	output logic          ruse,
	input  logic          we_val,
	input  logic [AW-1:0] waddr_val,
	input  logic [DW-1:0] wval,
	input  logic          we_next,
	input  logic [AW-1:0] waddr_next,
	input  logic [HW-1:0] wnext,
	input  logic          we_prior,
	input  logic [AW-1:0] waddr_prior,
	input  logic [HW-1:0] wprior,
	input  logic          we_use,
	input  logic [AW-1:0] waddr_use,
	input  logic          wuse
);
	logic [DW-1:0] val_mem   [2**AW];
	logic [HW-1:0] next_mem  [2**AW];
	logic [HW-1:0] prior_mem [2**AW];
	logic          use_mem   [2**AW];

	always_ff @(posedge clk) begin
		if (we_val) val_mem[waddr_val] <= wval;
		rval <= val_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (we_next) next_mem[waddr_next] <= wnext;
		rnext <= next_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (we_prior) prior_mem[waddr_prior] <= wprior;
		rprior <= prior_mem[raddr];
	end

	// valid only below the never-used count; at or above it a node is free
	always_ff @(posedge clk) begin
		if (we_use) use_mem[waddr_use] <= wuse;
		ruse <= use_mem[raddr];
	end
endmodule

>>> dv/doubly_linked_list_engine_tb.sv
// ----------------------------------------------------------------------------
// doubly_linked_list_engine_tb
// Self-checking bench for the node-pool linked list engine.
// ----------------------------------------------------------------------------
// Commands go in at the falling edge; every accepted transfer is mirrored into
// a list model that works out the one result each command returns. Results
// are taken at the rising edge and compared field by field, oldest first.
// Run: directed corner cases, random mixed traffic on a short list, a fill
// to the pool limit and a clear, then more random traffic.
// ----------------------------------------------------------------------------
module doubly_linked_list_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          CAP     = 1024;
	localparam logic [10:0] END_H   = 11'd1024;
	localparam logic [10:0] FRONT_H = 11'd1025;
	localparam int          LIMIT   = 2_000_000;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] data;
		logic [10:0]        rh;
		logic [10:0]        nh;
		logic [10:0]        ph;
		logic [10:0]        cnt;
	} list_result_t;

	// list mirror plus the queue of results still owed by the engine
	class list_scoreboard;
		logic signed [31:0] word [CAP];
		logic [10:0]        succ [CAP];
		logic [10:0]        pred [CAP];
		bit                 used [CAP];
		logic [10:0]        head, tail, free_head, fresh;
		int                 length;
		logic signed [31:0] front_word, end_word;
		list_result_t       owed [$];
		int                 errors;

		function new();
			foreach (used[i]) used[i] = 0;
			head = END_H; tail = FRONT_H; free_head = END_H; fresh = 0;
			length = 0; front_word = 0; end_word = 0; errors = 0;
		endfunction

		function logic [10:0] pred_of(logic [10:0] h);
			if (h == END_H) return tail;
			if (h < END_H) return pred[h];
			return FRONT_H;
		endfunction

		function void set_succ(logic [10:0] h, logic [10:0] v);
			if (h == FRONT_H) head = v;
			else if (h < END_H) succ[h] = v;
		endfunction

		function void set_pred(logic [10:0] h, logic [10:0] v);
			if (h == END_H) tail = v;
			else if (h < END_H) pred[h] = v;
		endfunction

		function bit live(logic [10:0] h);
			return h < END_H && used[h];
		endfunction

		// free list first, then never-used nodes; END_H means pool full
		function logic [10:0] link_before(logic [10:0] h, logic signed [31:0] v);
			logic [10:0] n, p;
			if (free_head < END_H) begin
				n = free_head;
				free_head = succ[n];
			end else if (fresh < END_H) begin
				n = fresh;
				fresh++;
			end else
				return END_H;
			p = pred_of(h);
			word[n] = v; pred[n] = p; succ[n] = h;
			set_succ(p, n);
			set_pred(h, n);
			used[n] = 1;
			length++;
			return n;
		endfunction

		function logic [10:0] unlink(logic [10:0] n);
			logic [10:0] p, q;
			p = pred[n];
			q = succ[n];
			set_succ(p, q);
			set_pred(q, p);
			used[n] = 0;
			succ[n] = free_head;
			free_head = n;
			if (length > 0) length--;
			return q;
		endfunction

		function logic [10:0] walk(int k);
			logic [10:0] cur;
			cur = head;
			for (int i = 0; i < k && cur < END_H; i++) cur = succ[cur];
			return cur;
		endfunction

		function void note_command(logic [3:0] op, logic signed [31:0] v,
			logic [9:0] pos, logic [10:0] h);
			list_result_t r;
			logic [10:0] n;
			r = '0;
			case (op)
				dll_pkg::OP_PUSH_BACK, dll_pkg::OP_PUSH_FRONT: begin
					n = link_before(op == dll_pkg::OP_PUSH_BACK ? END_H : head, v);
					if (n == END_H) r.status = dll_pkg::ST_FULL; else r.rh = n;
				end
				dll_pkg::OP_POP_BACK, dll_pkg::OP_POP_FRONT: begin
					n = (op == dll_pkg::OP_POP_BACK) ? tail : head;
					if (length == 0 || n >= END_H) r.status = dll_pkg::ST_EMPTY;
					else void'(unlink(n));
				end
				dll_pkg::OP_RD_FRONT, dll_pkg::OP_WR_FRONT,
				dll_pkg::OP_RD_BACK, dll_pkg::OP_WR_BACK: begin
					n = (op == dll_pkg::OP_RD_FRONT || op == dll_pkg::OP_WR_FRONT) ? head : tail;
					if (length == 0 || n >= END_H) begin
						r.status = dll_pkg::ST_EMPTY;
						case (op)
							dll_pkg::OP_RD_FRONT: r.data = front_word;
							dll_pkg::OP_RD_BACK:  r.data = end_word;
							dll_pkg::OP_WR_FRONT: front_word = v;
							default:              end_word = v;
						endcase
					end else if (op == dll_pkg::OP_RD_FRONT || op == dll_pkg::OP_RD_BACK)
						r.data = word[n];
					else
						word[n] = v;
				end
				dll_pkg::OP_RD_INDEX, dll_pkg::OP_WR_INDEX: begin
					n = (pos >= length) ? END_H : walk(pos);
					if (n >= END_H) r.status = dll_pkg::ST_BAD_POS;
					else if (op == dll_pkg::OP_RD_INDEX) r.data = word[n];
					else word[n] = v;
				end
				dll_pkg::OP_INSERT: begin
					if (!(h == END_H || live(h))) r.status = dll_pkg::ST_BAD_HNDL;
					else begin
						n = link_before(h, v);
						if (n == END_H) r.status = dll_pkg::ST_FULL; else r.rh = n;
					end
				end
				dll_pkg::OP_ERASE: begin
					if (!live(h)) r.status = dll_pkg::ST_BAD_HNDL;
					else r.rh = unlink(h);
				end
				dll_pkg::OP_RD_NODE, dll_pkg::OP_WR_NODE: begin
					if (h == FRONT_H) begin
						if (op == dll_pkg::OP_RD_NODE) begin
							r.data = front_word; r.nh = head; r.ph = FRONT_H;
						end else front_word = v;
					end else if (h == END_H) begin
						if (op == dll_pkg::OP_RD_NODE) begin
							r.data = end_word; r.nh = END_H; r.ph = tail;
						end else end_word = v;
					end else if (live(h)) begin
						if (op == dll_pkg::OP_RD_NODE) begin
							r.data = word[h]; r.nh = succ[h]; r.ph = pred[h];
						end else word[h] = v;
					end else
						r.status = dll_pkg::ST_BAD_HNDL;
				end
				dll_pkg::OP_CLEAR: begin
					n = head;
					while (n < END_H && used[n]) n = unlink(n);
				end
				default: r.rh = head;
			endcase
			r.cnt = 11'(length);
			owed.insert(owed.size(), r);
		endfunction

		task report(string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endtask

		task check_result(list_result_t got);
			list_result_t e;
			if (owed.size() == 0) begin
				report($sformatf("unexpected result %p", got));
				return;
			end
			e = owed[0];
			owed.delete(0);
			if (got.status !== e.status)
				report($sformatf("status %0d, want %0d", got.status, e.status));
			if (got.data !== e.data)
				report($sformatf("data %0d, want %0d", got.data, e.data));
			if (got.rh !== e.rh)
				report($sformatf("result_handle %0d, want %0d", got.rh, e.rh));
			if (got.nh !== e.nh)
				report($sformatf("next_handle %0d, want %0d", got.nh, e.nh));
			if (got.ph !== e.ph)
				report($sformatf("prior_handle %0d, want %0d", got.ph, e.ph));
			if (got.cnt !== e.cnt)
				report($sformatf("element_count %0d, want %0d", got.cnt, e.cnt));
		endtask
	endclass

	logic               clk = 0;
	logic               arst_n = 0;
	logic               start = 0;
	logic               busy;
	logic [3:0]         opcode = dll_pkg::OP_BEGIN;
	logic signed [31:0] value = 0;
	logic [9:0]         position = 0;
	logic [10:0]        node_handle = 0;
	logic               done;
	logic [2:0]         status;
	logic signed [31:0] data;
	logic [10:0]        result_handle, next_handle, prior_handle, element_count;

	list_scoreboard sb = new();
	int  cycles = 0;
	bit  burst = 0;   // when set, the sender never idles

	doubly_linked_list_engine uut (
		.clk, .arst_n, .start, .busy, .opcode, .value, .position, .node_handle,
		.done, .status, .data, .result_handle, .next_handle, .prior_handle,
		.element_count
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("** doubly_linked_list_engine: FAILED **");
			$finish;
		end
	end

	// results are one-cycle strobes and cannot be held off
	always @(posedge clk)
		if (arst_n && done)
			sb.check_result('{status, data, result_handle, next_handle, prior_handle,
				element_count});

	// one command transfer; start stays high afterwards so back-to-back
	// commands need no low cycle
	task send(logic [3:0] op, logic signed [31:0] v, logic [9:0] pos,
		logic [10:0] h);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			start = 0;
			repeat (gap) @(negedge clk);
		end
		start = 1; opcode = op; value = v; position = pos; node_handle = h;
		do @(posedge clk); while (busy);
		sb.note_command(op, v, pos, h);
		@(negedge clk);
	endtask

	// hold off until every owed result is back
	task drain();
		start = 0;
		while (sb.owed.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function logic signed [31:0] rand_word();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return -1;
			default: return $urandom;
		endcase
	endfunction

	// mostly live nodes, sometimes markers or arbitrary (often free) numbers
	function logic [10:0] rand_handle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60 && sb.length > 0) return sb.walk($urandom_range(0, sb.length - 1));
		if (r < 75) return $urandom_range(0, 1) ? END_H : FRONT_H;
		return 11'($urandom_range(0, 1025));
	endfunction

	task random_command(int cap_len);
		int r;
		logic [3:0] op;
		logic [9:0] pos;
		r = $urandom_range(0, 99);
		if (sb.length > cap_len && r < 35)
			op = $urandom_range(0, 1) ? dll_pkg::OP_POP_BACK : dll_pkg::OP_ERASE;
		else if (r < 25)
			op = $urandom_range(0, 1) ? dll_pkg::OP_PUSH_BACK : dll_pkg::OP_PUSH_FRONT;
		else if (r < 30) op = dll_pkg::OP_INSERT;
		else if (r == 99) op = dll_pkg::OP_CLEAR;
		else op = 4'($urandom_range(0, 15));
		if (op == dll_pkg::OP_CLEAR && r != 99) op = dll_pkg::OP_BEGIN;
		pos = ($urandom_range(0, 3) != 0) ? 10'($urandom_range(0, sb.length))
			: 10'($urandom_range(0, 1023));
		if (op == dll_pkg::OP_ERASE && sb.length > 0 && $urandom_range(0, 1))
			send(op, rand_word(), pos, sb.walk($urandom_range(0, sb.length - 1)));
		else
			send(op, rand_word(), pos, rand_handle());
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// empty list: marker words, pops, bad positions and handles
		send(dll_pkg::OP_RD_FRONT, 0, 0, 0);
		send(dll_pkg::OP_RD_BACK, 0, 0, 0);
		send(dll_pkg::OP_WR_FRONT, 32'sh7FFFFFFF, 0, 0);
		send(dll_pkg::OP_WR_BACK, 32'sh80000000, 0, 0);
		send(dll_pkg::OP_RD_NODE, 0, 0, FRONT_H);
		send(dll_pkg::OP_RD_NODE, 0, 0, END_H);
		send(dll_pkg::OP_POP_BACK, 0, 0, 0);
		send(dll_pkg::OP_POP_FRONT, 0, 0, 0);
		send(dll_pkg::OP_RD_INDEX, 0, 0, 0);
		send(dll_pkg::OP_ERASE, 0, 0, END_H);
		send(dll_pkg::OP_INSERT, 5, 0, FRONT_H);
		send(dll_pkg::OP_BEGIN, 0, 0, 0);
		// build a few nodes and poke them
		send(dll_pkg::OP_INSERT, 32'sh7FFFFFFF, 0, END_H);
		send(dll_pkg::OP_PUSH_FRONT, 32'sh80000000, 0, 0);
		send(dll_pkg::OP_PUSH_BACK, -1, 10'h3FF, 11'h7FF);
		send(dll_pkg::OP_RD_INDEX, 0, 2, 0);
		send(dll_pkg::OP_WR_INDEX, 9, 10'd1023, 0);
		send(dll_pkg::OP_RD_NODE, 0, 0, 0);
		send(dll_pkg::OP_WR_NODE, 77, 0, 1);
		send(dll_pkg::OP_RD_NODE, 0, 0, 11'd5);
		send(dll_pkg::OP_ERASE, 0, 0, 0);
		send(dll_pkg::OP_WR_NODE, 3, 0, FRONT_H);
		send(dll_pkg::OP_BEGIN, 0, 0, 0);
		send(dll_pkg::OP_CLEAR, 0, 0, 0);
		send(dll_pkg::OP_RD_NODE, 0, 0, END_H);
		drain();

		// random traffic on a short list, with and without sender gaps
		for (int i = 0; i < 300; i++) begin
			if (i % 60 == 0) burst = $urandom_range(0, 1);
			random_command(40);
		end
		drain();
		burst = 0;

		// fill the pool to its limit, then overflow and clear
		while (sb.fresh < END_H || sb.free_head < END_H) begin
			send($urandom_range(0, 1) ? dll_pkg::OP_PUSH_BACK : dll_pkg::OP_PUSH_FRONT,
				rand_word(), 0, 0);
			if ($urandom_range(0, 99) == 0)
				send(dll_pkg::OP_RD_INDEX, 0, 10'($urandom_range(0, sb.length - 1)), 0);
		end
		send(dll_pkg::OP_PUSH_BACK, 1, 0, 0);
		send(dll_pkg::OP_INSERT, 2, 0, END_H);
		send(dll_pkg::OP_WR_INDEX, 4, 10'd1023, 0);
		send(dll_pkg::OP_RD_INDEX, 0, 10'd1023, 0);
		send(dll_pkg::OP_RD_NODE, 0, 0, END_H);
		send(dll_pkg::OP_CLEAR, 0, 0, 0);
		drain();

		// random traffic again, now reusing nodes from the free list
		for (int i = 0; i < 300; i++) begin
			if (i % 50 == 0) burst = $urandom_range(0, 1);
			random_command(60);
		end
		drain();
		repeat (20) @(negedge clk);

		if (sb.errors == 0)
			$display("** doubly_linked_list_engine: PASSED **");
		else
			$display("** doubly_linked_list_engine: FAILED **");
		$finish;
	end

endmodule

>>> files.f
hdl/dll_pkg.sv
hdl/dll_pool.sv
hdl/doubly_linked_list_engine.sv
dv/doubly_linked_list_engine_tb.sv
